// ===== rtl/e2it_pkg.sv =====
// Shared types, constants and helper functions for the epoch to ISO date-time text block.
// Used by the conversion pipeline, the record queue, the character emitter and the top level.
package e2it_pkg;

	localparam int EPOCH_W         = 39;
	localparam int DIGITS          = 14;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int IDX_W           = 5;

	localparam logic [IDX_W-1:0] IDX_DATE_LAST = 5'd9;
	localparam logic [IDX_W-1:0] IDX_TIME_LAST = 5'd18;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Accepted input span: 0000-01-01 through 9999-12-31 (23:59:59).
	localparam logic signed [EPOCH_W-1:0] SEC_LO = -39'sd62167219200;
	localparam logic signed [EPOCH_W-1:0] SEC_HI = 39'sd253402300799;
	localparam logic signed [EPOCH_W-1:0] DAY_LO = -39'sd719528;
	localparam logic signed [EPOCH_W-1:0] DAY_HI = 39'sd2932896;

	// Offsets that move day 0 to one full 400-year cycle before 0000-03-01,
	// so that every legal value is non-negative.
	localparam logic [21:0]        DAY_OFS = 22'd865565;
	localparam logic [EPOCH_W-1:0] SEC_OFS = 39'd74784816000;

	// Reciprocals for exact floor division by constants: ceil(2^(N+L) / D).
	localparam logic [32:0] M675  = 33'(((64'd1 << 42) + 64'd674) / 64'd675);
	localparam logic [22:0] MERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [17:0] MHOUR = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam logic [18:0] M1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [12:0] MMIN  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam logic [18:0] M365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [14:0] M100  = 15'(((64'd1 << 21) + 64'd99) / 64'd100);

	// One converted item. dig holds, from index 0: year (4), month (2), day (2),
	// hour (2), minute (2), second (2), each as a BCD digit.
	typedef struct packed {
		logic                   oor;
		logic                   cmd;
		logic [DIGITS-1:0][3:0] dig;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Two BCD digits of a value below 100.
	function automatic logic [7:0] bcd2(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] ones;
		tens = '0;
		for (int k = 1; k <= 9; k++) begin
			tens = tens + 4'(v >= 7'(10 * k));
		end
		ones = v - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
		return {tens, ones[3:0]};
	endfunction

	// Day of the March-based year on which month index mp starts.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] s;
		unique case (mp)
			4'd0:  s = 9'd0;
			4'd1:  s = 9'd31;
			4'd2:  s = 9'd61;
			4'd3:  s = 9'd92;
			4'd4:  s = 9'd122;
			4'd5:  s = 9'd153;
			4'd6:  s = 9'd184;
			4'd7:  s = 9'd214;
			4'd8:  s = 9'd245;
			4'd9:  s = 9'd275;
			4'd10: s = 9'd306;
			4'd11: s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/e2it_front.sv =====
// Front end: accepts epoch items, range-checks them and converts them to BCD date and time
// digits in an eleven-stage pipeline. Depends on e2it_pkg; feeds e2it_queue.
module e2it_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  in_cmd,
	input  logic signed [e2it_pkg::EPOCH_W-1:0]   in_epoch,
	input  e2it_pkg::qstat_t                      qstat,
	output logic                                  push,
	output e2it_pkg::rec_t                        rec
);
	import e2it_pkg::*;

	typedef struct packed {
		logic cmd;
		logic oor;
	} tag_t;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	tag_t tag_s7, tag_s8, tag_s9, tag_s10, tag_s11;

	// The whole pipeline holds only when its last stage cannot hand over.
	assign en       = !(vld_s11 && qstat.full);
	assign in_ready = en;
	assign push     = vld_s11 && !qstat.full;

	// Stage 1: range check and offset into non-negative counts.
	logic               oor_in;
	logic [EPOCH_W-1:0] sec_sh;
	logic [21:0]        day_sh;
	logic [31:0]        u_s1;
	logic [6:0]         lo_s1;
	logic [21:0]        zd_s1;

	always_comb begin
		if (in_cmd) begin
			oor_in = (in_epoch < SEC_LO) || (in_epoch > SEC_HI);
		end else begin
			oor_in = (in_epoch < DAY_LO) || (in_epoch > DAY_HI);
		end
		sec_sh = $unsigned(in_epoch) + SEC_OFS;
		day_sh = in_epoch[21:0] + DAY_OFS;
	end

	// Stage 2: seconds / 128 / 675 gives whole days.
	logic [64:0] p675;
	logic [21:0] q_s2;
	logic [31:0] u_s2;
	logic [6:0]  lo_s2;
	logic [21:0] zd_s2;
	assign p675 = 65'(u_s1) * 65'(M675);

	// Stage 3: seconds of the day and the day number in use.
	logic [31:0] r675;
	logic [16:0] rem_s3;
	logic [21:0] z_s3;
	assign r675 = u_s2 - 32'(q_s2) * 32'd675;

	// Stage 4: 400-year cycle and hour.
	logic [44:0] pera;
	logic [34:0] phour;
	logic [4:0]  era_s4;
	logic [4:0]  hh_s4;
	logic [21:0] z_s4;
	logic [16:0] rem_s4;
	assign pera  = 45'(z_s3) * 45'(MERA);
	assign phour = 35'(rem_s3) * 35'(MHOUR);

	// Stage 5: day of the cycle and seconds within the hour.
	logic [17:0] doe_s5;
	logic [11:0] rm_s5;
	logic [4:0]  era_s5;
	logic [4:0]  hh_s5;

	// Stage 6: leap-corrected day count and minute.
	logic [36:0] p1460;
	logic [24:0] pmin;
	logic [2:0]  cent;
	logic [17:0] t_s6;
	logic [17:0] doe_s6;
	logic [4:0]  era_s6;
	logic [4:0]  hh_s6;
	logic [5:0]  mm_s6;
	logic [11:0] rm_s6;
	assign p1460 = 37'(doe_s5) * 37'(M1460);
	assign pmin  = 25'(rm_s5) * 25'(MMIN);
	assign cent  = 3'(doe_s5 >= 18'd36524) + 3'(doe_s5 >= 18'd73048)
		+ 3'(doe_s5 >= 18'd109572) + 3'(doe_s5 >= 18'd146096);

	// Stage 7: year of the cycle and second.
	logic [36:0] p365;
	logic [8:0]  yoe_s7;
	logic [17:0] doe_s7;
	logic [4:0]  era_s7;
	logic [4:0]  hh_s7;
	logic [5:0]  mm_s7;
	logic [5:0]  ss_s7;
	assign p365 = 37'(t_s6) * 37'(M365);

	// Stage 8: day of the March-based year; time digits.
	logic [1:0]  ycent;
	logic [17:0] ystart;
	logic [8:0]  doy_s8;
	logic [8:0]  yoe_s8;
	logic [4:0]  era_s8;
	logic [23:0] tbcd_s8;
	assign ycent  = 2'(yoe_s7 >= 9'd100) + 2'(yoe_s7 >= 9'd200) + 2'(yoe_s7 >= 9'd300);
	assign ystart = 18'(yoe_s7) * 18'd365 + 18'(yoe_s7[8:2]) - 18'(ycent);

	// Stage 9: month, day and civil year.
	logic [3:0]  mp;
	logic [8:0]  mstart;
	logic [3:0]  mon;
	logic [15:0] yfull;
	logic [4:0]  d_s9;
	logic [3:0]  m_s9;
	logic [13:0] y_s9;
	logic [23:0] tbcd_s9;

	always_comb begin
		mp = '0;
		for (int k = 1; k <= 11; k++) begin
			mp = mp + 4'(doy_s8 >= month_start(4'(k)));
		end
		mstart = month_start(mp);
		mon    = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
		yfull  = 16'(yoe_s8) + 16'(era_s8) * 16'd400 + 16'(mon <= 4'd2) - 16'd400;
	end

	// Stage 10: year split in hundreds; month and day digits.
	logic [28:0] p100;
	logic [6:0]  yhi_s10;
	logic [13:0] y_s10;
	logic [15:0] dbcd_s10;
	logic [23:0] tbcd_s10;
	assign p100 = 29'(y_s9) * 29'(M100);

	// Stage 11: low two year digits.
	logic [6:0]  yhi_s11;
	logic [6:0]  ylo_s11;
	logic [15:0] dbcd_s11;
	logic [23:0] tbcd_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1   <= '{cmd: in_cmd, oor: oor_in};
			u_s1     <= sec_sh[EPOCH_W-1:7];
			lo_s1    <= sec_sh[6:0];
			zd_s1    <= day_sh;

			tag_s2   <= tag_s1;
			q_s2     <= p675[63:42];
			u_s2     <= u_s1;
			lo_s2    <= lo_s1;
			zd_s2    <= zd_s1;

			tag_s3   <= tag_s2;
			rem_s3   <= {r675[9:0], lo_s2};
			z_s3     <= tag_s2.cmd ? q_s2 : zd_s2;

			tag_s4   <= tag_s3;
			era_s4   <= pera[44:40];
			hh_s4    <= phour[33:29];
			z_s4     <= z_s3;
			rem_s4   <= rem_s3;

			tag_s5   <= tag_s4;
			doe_s5   <= 18'(z_s4 - 22'(era_s4) * 22'd146097);
			rm_s5    <= 12'(rem_s4 - 17'(hh_s4) * 17'd3600);
			era_s5   <= era_s4;
			hh_s5    <= hh_s4;

			tag_s6   <= tag_s5;
			t_s6     <= doe_s5 - 18'(p1460[35:29]) + 18'(cent)
				- 18'(doe_s5 == 18'd146096);
			doe_s6   <= doe_s5;
			era_s6   <= era_s5;
			hh_s6    <= hh_s5;
			mm_s6    <= pmin[23:18];
			rm_s6    <= rm_s5;

			tag_s7   <= tag_s6;
			yoe_s7   <= p365[35:27];
			doe_s7   <= doe_s6;
			era_s7   <= era_s6;
			hh_s7    <= hh_s6;
			mm_s7    <= mm_s6;
			ss_s7    <= 6'(rm_s6 - 12'(mm_s6) * 12'd60);

			tag_s8   <= tag_s7;
			doy_s8   <= 9'(doe_s7 - ystart);
			yoe_s8   <= yoe_s7;
			era_s8   <= era_s7;
			tbcd_s8  <= {bcd2(7'(hh_s7)), bcd2(7'(mm_s7)), bcd2(7'(ss_s7))};

			tag_s9   <= tag_s8;
			d_s9     <= 5'(doy_s8 - mstart + 9'd1);
			m_s9     <= mon;
			y_s9     <= yfull[13:0];
			tbcd_s9  <= tbcd_s8;

			tag_s10  <= tag_s9;
			yhi_s10  <= p100[27:21];
			y_s10    <= y_s9;
			dbcd_s10 <= {bcd2(7'(m_s9)), bcd2(7'(d_s9))};
			tbcd_s10 <= tbcd_s9;

			tag_s11  <= tag_s10;
			yhi_s11  <= yhi_s10;
			ylo_s11  <= 7'(y_s10 - 14'(yhi_s10) * 14'd100);
			dbcd_s11 <= dbcd_s10;
			tbcd_s11 <= tbcd_s10;
		end
	end

	logic [7:0] yh_bcd;
	logic [7:0] yl_bcd;
	assign yh_bcd = bcd2(yhi_s11);
	assign yl_bcd = bcd2(ylo_s11);

	always_comb begin
		rec.oor     = tag_s11.oor;
		rec.cmd     = tag_s11.cmd;
		rec.dig[0]  = yh_bcd[7:4];
		rec.dig[1]  = yh_bcd[3:0];
		rec.dig[2]  = yl_bcd[7:4];
		rec.dig[3]  = yl_bcd[3:0];
		rec.dig[4]  = dbcd_s11[15:12];
		rec.dig[5]  = dbcd_s11[11:8];
		rec.dig[6]  = dbcd_s11[7:4];
		rec.dig[7]  = dbcd_s11[3:0];
		rec.dig[8]  = tbcd_s11[23:20];
		rec.dig[9]  = tbcd_s11[19:16];
		rec.dig[10] = tbcd_s11[15:12];
		rec.dig[11] = tbcd_s11[11:8];
		rec.dig[12] = tbcd_s11[7:4];
		rec.dig[13] = tbcd_s11[3:0];
	end

endmodule

// ===== rtl/e2it_queue.sv =====
// Record queue between the conversion pipeline and the character emitter.
// Depends on e2it_pkg for the record and status types.
module e2it_queue #(
	parameter int DEPTH = e2it_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  e2it_pkg::rec_t    wdata,
	input  logic              pop,
	output e2it_pkg::rec_t    head,
	output e2it_pkg::qstat_t  qstat
);
	import e2it_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/e2it_emit.sv =====
// Back end: walks the record at the head of the queue and sends one ASCII character
// per transaction through an output register. Depends on e2it_pkg.
module e2it_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  e2it_pkg::rec_t    head,
	input  e2it_pkg::qstat_t  qstat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_char,
	output logic              out_last,
	output logic              out_oor
);
	import e2it_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             oor_q;

	logic       load;
	logic       take;
	logic       last;
	logic       is_dig;
	logic [3:0] dsel;
	logic [7:0] sep;
	logic [7:0] ch;

	assign load = !valid_q || out_ready;
	assign take = load && !qstat.empty;
	assign last = head.oor || (head.cmd ? (idx_q == IDX_TIME_LAST) : (idx_q == IDX_DATE_LAST));
	assign pop  = take && last;

	always_comb begin
		is_dig = 1'b1;
		dsel   = 4'd0;
		sep    = 8'd0;
		unique case (idx_q)
			5'd0:  dsel = head.dig[0];
			5'd1:  dsel = head.dig[1];
			5'd2:  dsel = head.dig[2];
			5'd3:  dsel = head.dig[3];
			5'd4:  begin is_dig = 1'b0; sep = CH_DASH; end
			5'd5:  dsel = head.dig[4];
			5'd6:  dsel = head.dig[5];
			5'd7:  begin is_dig = 1'b0; sep = CH_DASH; end
			5'd8:  dsel = head.dig[6];
			5'd9:  dsel = head.dig[7];
			5'd10: begin is_dig = 1'b0; sep = CH_SPACE; end
			5'd11: dsel = head.dig[8];
			5'd12: dsel = head.dig[9];
			5'd13: begin is_dig = 1'b0; sep = CH_COLON; end
			5'd14: dsel = head.dig[10];
			5'd15: dsel = head.dig[11];
			5'd16: begin is_dig = 1'b0; sep = CH_COLON; end
			5'd17: dsel = head.dig[12];
			5'd18: dsel = head.dig[13];
			default: is_dig = 1'b0;
		endcase
		if (head.oor) begin
			ch = 8'd0;
		end else if (is_dig) begin
			ch = CH_ZERO | {4'd0, dsel};
		end else begin
			ch = sep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= !qstat.empty;
			end
			if (take) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= ch;
			last_q <= last;
			oor_q  <= head.oor;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;
	assign out_oor   = oor_q;

endmodule

// ===== rtl/epoch_to_iso_datetime_text.sv =====
// Top level of the epoch to ISO-8601 text converter: conversion pipeline, record queue
// and character emitter. Depends on e2it_pkg, e2it_front, e2it_queue and e2it_emit.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata: epoch_value, tuser: cmd
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata: text_char, tlast, tuser
//
// An item passes through the conversion pipeline before it enters the queue, then
// leaves as 10 characters (date), 19 characters (date and time) or one out-of-range
// character, one per cycle while m_axis_tready stays high; the output channel sets the rate.
// A new item is taken every cycle until the queue fills; s_axis_tready drops only while
// the queue is full and the last pipeline stage holds an item. Reset clears only the
// pipeline valid bits, queue pointers and count, emitter state; there is no clearing pass.
module epoch_to_iso_datetime_text #(
	parameter int QUEUE_DEPTH = e2it_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [38:0] epoch_value (signed), [39] zero pad
	input  logic        s_axis_tuser,   // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] text_char
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] out_of_range
);
	import e2it_pkg::*;

	qstat_t qstat;
	rec_t   push_rec;
	rec_t   head_rec;
	logic   push;
	logic   pop;

	e2it_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_epoch ($signed(s_axis_tdata[EPOCH_W-1:0])),
		.qstat    (qstat),
		.push     (push),
		.rec      (push_rec)
	);

	e2it_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_rec),
		.pop    (pop),
		.head   (head_rec),
		.qstat  (qstat)
	);

	e2it_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_rec),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_oor   (m_axis_tuser)
	);

	// The pipeline must never write into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("record written into a full queue");

	// The emitter must never retire a record from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("record retired from an empty queue");

	// An out-of-range result is a single zero character that closes its item.
	a_oor_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'h00)))
		else $error("out-of-range result is not a lone zero character");

	// Input back-pressure comes only from a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> qstat.full)
		else $error("input stalled while the queue had room");

endmodule
